FILE: sv/cmlst_pkg.sv
// cmlst_pkg: shared types and constants for the chaotic map laminar statistics block
// no dependencies; used by the interfaces, the map unit, the statistics unit and the top level

package cmlst_pkg;

    localparam int VAL_W       = 48;
    localparam int WIDTH_W     = 47;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 48;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;

    localparam int SQ_DIGIT_W  = 16;
    localparam int SQ_DIGITS   = 3;
    localparam int ACC_W       = 96;
    localparam int QUO_W       = 47;
    localparam int DEN_W       = 63;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_SEED      = 2'd0;
    localparam t_cmd CMD_TRANSIENT = 2'd1;
    localparam t_cmd CMD_MEASURE   = 2'd2;

    localparam t_cfg_idx CFG_GAIN   = 2'd0;
    localparam t_cfg_idx CFG_OFFSET = 2'd1;
    localparam t_cfg_idx CFG_CENTER = 2'd2;
    localparam t_cfg_idx CFG_WIDTH  = 2'd3;

    localparam logic [VAL_W-1:0]   GAIN_RST   = 48'sd5277655813325;
    localparam logic [VAL_W-1:0]   OFFSET_RST = -48'sd3223119380779;
    localparam logic [VAL_W-1:0]   CENTER_RST = -48'sd1940561057211;
    localparam logic [WIDTH_W-1:0] WIDTH_RST  = 47'd109951162778;

    typedef struct packed {
        logic update;
        t_cmd cmd;
    } t_stats_ctl;

    typedef struct packed {
        logic             laminar;
        logic             done;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] total;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] peak;
    } t_stats_out;

endpackage

FILE: sv/cmlst_if.sv
// cmlst_in_if, cmlst_out_if, cmlst_cfg_if: valid/ready channels of the block
// depends on cmlst_pkg for field widths

interface cmlst_in_if;
    logic                              valid;
    logic                              ready;
    cmlst_pkg::t_cmd                   cmd;
    logic signed [cmlst_pkg::VAL_W-1:0] seed_value;

    modport source (output valid, output cmd, output seed_value, input ready);
    modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface cmlst_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmlst_pkg::VAL_W-1:0] next_value;
    logic                               laminar_now;
    logic                               episode_done;
    logic [cmlst_pkg::CNT_W-1:0]        episode_length;
    logic [cmlst_pkg::CNT_W-1:0]        episode_total;
    logic [cmlst_pkg::SUM_W-1:0]        length_total;
    logic [cmlst_pkg::CNT_W-1:0]        length_peak;

    modport source (
        output valid, output next_value, output laminar_now, output episode_done,
        output episode_length, output episode_total, output length_total,
        output length_peak, input ready
    );
    modport sink (
        input valid, input next_value, input laminar_now, input episode_done,
        input episode_length, input episode_total, input length_total,
        input length_peak, output ready
    );
endinterface

interface cmlst_cfg_if;
    logic                        valid;
    logic                        ready;
    cmlst_pkg::t_cfg_idx         index;
    logic [cmlst_pkg::VAL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/cmlst_map_unit.sv
// cmlst_map_unit: one map iteration x' = gain / (1 + x^2) + offset, computed sequentially
// square on a 48x16 multiplier, then a restoring divider one bit a cycle; uses cmlst_pkg

module cmlst_map_unit #(
    parameter int FRAC_BITS = 40
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_value,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_gain,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_offset,
    output logic                               o_done,
    output logic signed [cmlst_pkg::VAL_W-1:0] o_value
);

    localparam int VAL_W   = cmlst_pkg::VAL_W;
    localparam int ACC_W   = cmlst_pkg::ACC_W;
    localparam int QUO_W   = cmlst_pkg::QUO_W;
    localparam int DEN_W   = cmlst_pkg::DEN_W;
    localparam int DIG_W   = cmlst_pkg::SQ_DIGIT_W;
    localparam int DVD_W   = QUO_W + FRAC_BITS;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int PROD_W  = VAL_W + DIG_W;

    localparam logic [63:0]      DEN_CAP = 64'd1 << 62;
    localparam logic [63:0]      ONE     = 64'd1 << FRAC_BITS;
    localparam logic [ACC_W-1:0] CAP_LIM = ACC_W'(DEN_CAP - ONE);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_SQR, S_DEN, S_DIV, S_FIN} t_state;

    function automatic logic [VAL_W-1:0] f_mag(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [VAL_W-1:0]    r_mag;
    logic [ACC_W-1:0]    r_acc;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic signed [VAL_W-1:0] r_value;
    logic                r_done;

    logic [DIG_W-1:0]    w_digit;
    logic [PROD_W-1:0]   w_prod;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    w_sq;
    logic [DEN_W-1:0]    n_den;
    logic [VAL_W-1:0]    w_num;
    logic [DVD_W-1:0]    w_dvd;
    logic [DEN_W:0]      w_rs;
    logic [DEN_W:0]      w_diff;
    logic                w_ge;
    logic signed [QUO_W+1:0] w_quo;
    logic signed [QUO_W+1:0] w_sq_sgn;
    logic signed [VAL_W+1:0] w_sum;
    logic signed [VAL_W-1:0] n_value;

    // square: one 16 bit digit of |x| per cycle, most significant first
    always_comb begin
        w_digit = r_mag[r_step[1:0]*DIG_W +: DIG_W];
        w_prod  = r_mag * w_digit;
        n_acc   = {r_acc[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(w_prod);
    end

    // denominator 1 + x^2, held at the cap
    always_comb begin
        w_sq  = r_acc >> FRAC_BITS;
        n_den = (w_sq > CAP_LIM) ? DEN_W'(DEN_CAP) : DEN_W'(ONE) + w_sq[DEN_W-1:0];
        w_num = f_mag(i_gain);
        w_dvd = {w_num[QUO_W-1:0], {FRAC_BITS{1'b0}}};
    end

    // restoring divider step
    always_comb begin
        w_rs   = {r_rem, r_quo[QUO_W-1]};
        w_ge   = w_rs >= {1'b0, r_den};
        w_diff = w_rs - {1'b0, r_den};
    end

    // sign, offset and saturation
    always_comb begin
        w_quo    = {2'b00, r_quo};
        w_sq_sgn = i_gain[VAL_W-1] ? -w_quo : w_quo;
        w_sum    = {w_sq_sgn[QUO_W+1], w_sq_sgn} + {{2{i_offset[VAL_W-1]}}, i_offset};
        if (w_sum[VAL_W+1:VAL_W-1] == 3'b000 || w_sum[VAL_W+1:VAL_W-1] == 3'b111) begin
            n_value = w_sum[VAL_W-1:0];
        end else if (w_sum[VAL_W+1]) begin
            n_value = VAL_MIN;
        end else begin
            n_value = VAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mag   <= f_mag(i_value);
                        r_acc   <= '0;
                        r_step  <= STEP_W'(cmlst_pkg::SQ_DIGITS - 1);
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_acc <= n_acc;
                    if (r_step == '0) begin
                        r_state <= S_DEN;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_DEN: begin
                    r_den   <= n_den;
                    r_rem   <= DEN_W'(w_dvd[DVD_W-1:QUO_W]);
                    r_quo   <= w_dvd[QUO_W-1:0];
                    r_step  <= STEP_W'(QUO_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rs[DEN_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    if (r_step == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_FIN: begin
                    r_value <= n_value;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

FILE: sv/cmlst_stats.sv
// cmlst_stats: laminar window tests, episode state and the running episode statistics
// uses cmlst_pkg for the control and result structs

module cmlst_stats #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cmlst_pkg::t_stats_ctl              i_ctl,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_old_value,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_new_value,
    input  logic signed [cmlst_pkg::VAL_W-1:0] i_center,
    input  logic [cmlst_pkg::WIDTH_W-1:0]      i_width,
    output cmlst_pkg::t_stats_out              o_stats
);

    localparam int VAL_W = cmlst_pkg::VAL_W;
    localparam int CNT_W = cmlst_pkg::CNT_W;
    localparam int SUM_W = cmlst_pkg::SUM_W;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    function automatic logic f_inside(
        input logic [VAL_W-1:0]              v,
        input logic [VAL_W-1:0]              c,
        input logic [cmlst_pkg::WIDTH_W-1:0] w
    );
        logic [VAL_W:0] d;
        logic [VAL_W:0] m;
        d = {v[VAL_W-1], v} - {c[VAL_W-1], c};
        m = d[VAL_W] ? (~d + 1'b1) : d;
        return m <= {2'b00, w};
    endfunction

    logic                   r_in_ep;
    logic [LENGTH_BITS-1:0] r_run;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;
    logic [LENGTH_BITS-1:0] r_max;
    logic                   r_done;
    logic [LENGTH_BITS-1:0] r_len;

    logic                   n_in_ep;
    logic [LENGTH_BITS-1:0] n_run;
    logic [CNT_W-1:0]       n_count;
    logic [SUM_W-1:0]       n_sum;
    logic [LENGTH_BITS-1:0] n_max;
    logic                   n_done;
    logic [LENGTH_BITS-1:0] n_len;

    logic                   w_old_in;
    logic                   w_new_in;
    logic [SUM_W:0]         w_sum_ext;

    always_comb begin
        w_old_in  = f_inside(i_old_value, i_center, i_width);
        w_new_in  = f_inside(i_new_value, i_center, i_width);
        w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_run);

        n_in_ep = r_in_ep;
        n_run   = r_run;
        n_count = r_count;
        n_sum   = r_sum;
        n_max   = r_max;
        n_done  = 1'b0;
        n_len   = '0;

        case (i_ctl.cmd)
            cmlst_pkg::CMD_SEED: begin
                n_in_ep = 1'b0;
                n_run   = '0;
                n_count = '0;
                n_sum   = '0;
                n_max   = '0;
            end
            cmlst_pkg::CMD_TRANSIENT: begin
                n_in_ep = 1'b0;
                n_run   = '0;
            end
            cmlst_pkg::CMD_MEASURE: begin
                if (!r_in_ep) begin
                    if (!w_old_in && w_new_in) begin
                        n_in_ep = 1'b1;
                        n_run   = LENGTH_BITS'(1);
                    end
                end else if (!w_new_in) begin
                    n_in_ep = 1'b0;
                    n_done  = 1'b1;
                    n_len   = r_run;
                    n_run   = '0;
                    if (r_count != {CNT_W{1'b1}}) begin
                        n_count = r_count + 1'b1;
                    end
                    n_sum = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];
                    if (r_run > r_max) begin
                        n_max = r_run;
                    end
                end else if (r_run != LEN_MAX) begin
                    n_run = r_run + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ep <= 1'b0;
            r_run   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_max   <= '0;
            r_done  <= 1'b0;
            r_len   <= '0;
        end else if (i_ctl.update) begin
            r_in_ep <= n_in_ep;
            r_run   <= n_run;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_max   <= n_max;
            r_done  <= n_done;
            r_len   <= n_len;
        end
    end

    always_comb begin
        o_stats.laminar = r_in_ep;
        o_stats.done    = r_done;
        o_stats.length  = CNT_W'(SUM_W'(r_len));
        o_stats.total   = r_count;
        o_stats.sum     = r_sum;
        o_stats.peak    = CNT_W'(SUM_W'(r_max));
    end

endmodule

FILE: sv/chaotic_map_laminar_stats.sv
// chaotic_map_laminar_stats: top level, command sequencing, configuration registers, result register
// depends on cmlst_pkg, cmlst_if, cmlst_map_unit and cmlst_stats

// Iterates x' = map_gain / (1 + x^2) + map_offset in 48-bit signed fixed point and keeps
// statistics of laminar episodes around center_point. One transaction is taken at a time:
// a transient or measured step runs the map unit (squaring on its 48x16 multiplier, a
// denominator setup step, restoring division, then sign, offset and saturation) and is
// then evaluated and pushed; a seed or an unused command skips the map unit. Input ready
// returns once the result sits in the output register, so the next transaction may start
// while that result still waits to be taken. Configuration writes are always ready; to take effect
// on the next step, the user must make them between steps, as the block does not enforce it.

module chaotic_map_laminar_stats #(
    parameter int FRAC_BITS   = 40,
    parameter int LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cmlst_in_if.sink           i_in,
    cmlst_cfg_if.sink          i_cfg,
    cmlst_out_if.source        o_out
);

    localparam int VAL_W = cmlst_pkg::VAL_W;

    typedef enum logic [1:0] {S_IDLE, S_MAP, S_EVAL, S_PUSH} t_state;

    t_state                  r_state;
    cmlst_pkg::t_cmd         r_cmd;
    logic signed [VAL_W-1:0] r_seed;
    logic signed [VAL_W-1:0] r_cur;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    cmlst_pkg::t_stats_out   r_out_stats;

    logic signed [VAL_W-1:0]           r_gain;
    logic signed [VAL_W-1:0]           r_offset;
    logic signed [VAL_W-1:0]           r_center;
    logic [cmlst_pkg::WIDTH_W-1:0]     r_width;

    logic                    w_in_txn;
    logic                    w_start;
    logic                    w_push;
    logic                    w_map_done;
    logic signed [VAL_W-1:0] w_map_value;
    logic signed [VAL_W-1:0] n_cur;
    cmlst_pkg::t_stats_ctl   w_stats_ctl;
    cmlst_pkg::t_stats_out   w_stats;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_txn    = i_in.valid && (r_state == S_IDLE);
    assign w_start     = w_in_txn && (i_in.cmd == cmlst_pkg::CMD_TRANSIENT ||
                                      i_in.cmd == cmlst_pkg::CMD_MEASURE);
    assign w_push      = (r_state == S_PUSH) && (!r_out_valid || o_out.ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= cmlst_pkg::GAIN_RST;
            r_offset <= cmlst_pkg::OFFSET_RST;
            r_center <= cmlst_pkg::CENTER_RST;
            r_width  <= cmlst_pkg::WIDTH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cmlst_pkg::CFG_GAIN:   r_gain   <= i_cfg.data;
                cmlst_pkg::CFG_OFFSET: r_offset <= i_cfg.data;
                cmlst_pkg::CFG_CENTER: r_center <= i_cfg.data;
                cmlst_pkg::CFG_WIDTH:  r_width  <= i_cfg.data[cmlst_pkg::WIDTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cmlst_map_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (r_cur),
        .i_gain   (r_gain),
        .i_offset (r_offset),
        .o_done   (w_map_done),
        .o_value  (w_map_value)
    );

    assign w_stats_ctl.update = (r_state == S_EVAL);
    assign w_stats_ctl.cmd    = r_cmd;

    cmlst_stats #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_stats_ctl),
        .i_old_value (r_cur),
        .i_new_value (w_map_value),
        .i_center    (r_center),
        .i_width     (r_width),
        .o_stats     (w_stats)
    );

    always_comb begin
        case (r_cmd) inside
            cmlst_pkg::CMD_SEED:                           n_cur = r_seed;
            cmlst_pkg::CMD_TRANSIENT, cmlst_pkg::CMD_MEASURE: n_cur = w_map_value;
            default:                                       n_cur = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_txn) begin
                        r_cmd   <= i_in.cmd;
                        r_seed  <= i_in.seed_value;
                        r_state <= w_start ? S_MAP : S_EVAL;
                    end
                end
                S_MAP: begin
                    if (w_map_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_cur   <= n_cur;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_push) begin
                        r_out_value <= r_cur;
                        r_out_stats <= w_stats;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.next_value     = r_out_value;
    assign o_out.laminar_now    = r_out_stats.laminar;
    assign o_out.episode_done   = r_out_stats.done;
    assign o_out.episode_length = r_out_stats.length;
    assign o_out.episode_total  = r_out_stats.total;
    assign o_out.length_total   = r_out_stats.sum;
    assign o_out.length_peak    = r_out_stats.peak;

endmodule

FILE: sv/cmlst_checker.sv
// cmlst_checker: port-level assertions for chaotic_map_laminar_stats
// bound to the top level below; uses cmlst_pkg for widths

module cmlst_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [cmlst_pkg::VAL_W-1:0] i_next_value,
    input logic                               i_laminar_now,
    input logic                               i_episode_done,
    input logic [cmlst_pkg::CNT_W-1:0]        i_episode_length,
    input logic [cmlst_pkg::CNT_W-1:0]        i_episode_total,
    input logic [cmlst_pkg::CNT_W-1:0]        i_length_peak
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_value))
        else $error("stalled result changed");

    // one transaction at a time
    a_busy_after_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // a finished episode has a length and closes the episode
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_episode_done |->
            i_episode_length != '0 && !i_laminar_now && i_episode_total != '0)
        else $error("finished episode without length or count");

    a_no_done_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_episode_done |-> i_episode_length == '0)
        else $error("episode length without a finished episode");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_episode_done |-> i_length_peak >= i_episode_length)
        else $error("peak below the finished length");

endmodule

bind chaotic_map_laminar_stats cmlst_checker u_cmlst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_next_value     (o_out.next_value),
    .i_laminar_now    (o_out.laminar_now),
    .i_episode_done   (o_out.episode_done),
    .i_episode_length (o_out.episode_length),
    .i_episode_total  (o_out.episode_total),
    .i_length_peak    (o_out.length_peak)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for chaotic_map_laminar_stats, map iteration and laminar episode statistics
// depends on cmlst_pkg and the cmlst_*_if interfaces; drives seeds, steps and register writes

module tb;
    import cmlst_pkg::*;

    localparam int     FRAC       = 40;
    localparam int     LEN_W      = 32;
    localparam int     CYCLE_CAP  = 1_000_000;
    localparam int     DRAIN_WAIT = 60;
    localparam t_cmd   CMD_UNUSED = 2'd3;

    localparam logic [VAL_W-1:0]   FIX_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0]   FIX_MIN  = 48'h8000_0000_0000;
    localparam logic [VAL_W-1:0]   FIX_ONE  = 48'h0100_0000_0000;
    localparam logic [WIDTH_W-1:0] HALF_MAX = 47'h7FFF_FFFF_FFFF;
    localparam longint             FIX_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint             FIX_LO   = -64'sh0000_8000_0000_0000;
    localparam longint             UNIT_L   = 64'sd1 << FRAC;
    localparam logic [127:0]       DEN_CAP  = 128'd1 << 62;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             laminar;
        logic             done;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] total;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] peak;
    } t_orbit_point;

    logic i_clk;
    logic i_rst_n;

    cmlst_in_if  in_ch ();
    cmlst_cfg_if cfg_ch ();
    cmlst_out_if res_ch ();

    chaotic_map_laminar_stats u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    // map parameters and episode state as the block should hold them
    logic signed [VAL_W-1:0] gain_r;
    logic signed [VAL_W-1:0] offset_r;
    logic signed [VAL_W-1:0] center_r;
    logic [WIDTH_W-1:0]      width_r;
    logic signed [VAL_W-1:0] x_now;
    logic                    lam_open;
    logic [LEN_W-1:0]        run_len;
    logic [CNT_W-1:0]        ep_count;
    logic [SUM_W-1:0]        len_sum;
    logic [LEN_W-1:0]        len_max;

    t_orbit_point orbit_q[$];
    int           idle_pct;
    int           mismatches;
    int           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [VAL_W-1:0] map_iterate(input logic signed [VAL_W-1:0] x);
        longint       xs;
        longint       gs;
        longint       term;
        longint       total;
        logic [127:0] xm;
        logic [127:0] sq;
        logic [127:0] den;
        logic [127:0] quo;
        xs = x;
        gs = gain_r;
        xm = (xs < 0) ? 128'(-xs) : 128'(xs);
        sq = (xm * xm) >> FRAC;
        if (sq > DEN_CAP - (128'd1 << FRAC)) begin
            den = DEN_CAP;
        end else begin
            den = (128'd1 << FRAC) + sq;
        end
        quo = (gs < 0) ? 128'(-gs) : 128'(gs);
        // numerator keeps the low 47 bits of the gain magnitude
        quo = {81'd0, quo[VAL_W-2:0]};
        quo = (quo << FRAC) / den;
        term = longint'(quo[VAL_W-1:0]);
        if (gs < 0) begin
            term = -term;
        end
        total = term + longint'(offset_r);
        if (total > FIX_HI) begin
            total = FIX_HI;
        end else if (total < FIX_LO) begin
            total = FIX_LO;
        end
        return total[VAL_W-1:0];
    endfunction

    function automatic bit in_window(input logic signed [VAL_W-1:0] v);
        longint d;
        d = longint'(v) - longint'(center_r);
        if (d < 0) begin
            d = -d;
        end
        return d <= longint'(width_r);
    endfunction

    function automatic t_orbit_point advance_orbit(input t_cmd c,
                                                   input logic signed [VAL_W-1:0] seed);
        t_orbit_point            p;
        logic signed [VAL_W-1:0] nx;
        logic [LEN_W-1:0]        closed;
        bit                      old_in;
        bit                      new_in;
        bit                      done;
        closed = '0;
        done   = 1'b0;
        case (c)
            CMD_SEED: begin
                x_now    = seed;
                lam_open = 1'b0;
                run_len  = '0;
                ep_count = '0;
                len_sum  = '0;
                len_max  = '0;
            end
            CMD_TRANSIENT: begin
                x_now    = map_iterate(x_now);
                lam_open = 1'b0;
                run_len  = '0;
            end
            CMD_MEASURE: begin
                nx     = map_iterate(x_now);
                old_in = in_window(x_now);
                new_in = in_window(nx);
                if (!lam_open) begin
                    if (!old_in && new_in) begin
                        lam_open = 1'b1;
                        run_len  = 1;
                    end
                end else if (!new_in) begin
                    lam_open = 1'b0;
                    done     = 1'b1;
                    closed   = run_len;
                    run_len  = '0;
                    if (ep_count != '1) begin
                        ep_count = ep_count + 1;
                    end
                    if (len_sum > {SUM_W{1'b1}} - SUM_W'(closed)) begin
                        len_sum = '1;
                    end else begin
                        len_sum = len_sum + SUM_W'(closed);
                    end
                    if (closed > len_max) begin
                        len_max = closed;
                    end
                end else if (run_len != '1) begin
                    run_len = run_len + 1;
                end
                x_now = nx;
            end
            default: begin
            end
        endcase
        p.value   = x_now;
        p.laminar = lam_open;
        p.done    = done;
        p.length  = closed;
        p.total   = ep_count;
        p.sum     = len_sum;
        p.peak    = len_max;
        return p;
    endfunction

    function automatic logic [VAL_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VAL_W-1:0];
    endfunction

    // roughly +-1/16 around a nominal value
    function automatic logic [VAL_W-1:0] jitter48();
        longint j;
        j = longint'($urandom_range(1 << 20)) - (1 << 19);
        return VAL_W'(j) << 17;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic step_map(input t_cmd c, input logic [VAL_W-1:0] seed);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= c;
        in_ch.seed_value <= seed;
        do @(posedge i_clk); while (!in_ch.ready);
        orbit_q = {orbit_q, advance_orbit(c, seed)};
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (orbit_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [VAL_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_GAIN:   gain_r   = data;
            CFG_OFFSET: offset_r = data;
            CFG_CENTER: center_r = data;
            CFG_WIDTH:  width_r  = data[WIDTH_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_map_setup(input logic [VAL_W-1:0] g, input logic [VAL_W-1:0] o,
                                  input logic [VAL_W-1:0] c, input logic [WIDTH_W-1:0] w);
        settle();
        write_reg(CFG_GAIN, g);
        write_reg(CFG_OFFSET, o);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_WIDTH, {1'b0, w});
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_orbit_phase(input int n);
        int     pick;
        longint v;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // seeds across the attractor, -3 to 2
                v = -3 * UNIT_L + longint'($urandom_range(5 * 1048576 - 1)) * 1048576
                    + longint'($urandom_range(1048575));
                step_map(CMD_SEED, v[VAL_W-1:0]);
            end else if (pick < 6) begin
                step_map(CMD_SEED, rand48());
            end else if (pick < 11) begin
                step_map(CMD_TRANSIENT, rand48());
            end else if (pick < 13) begin
                step_map(CMD_UNUSED, rand48());
            end else begin
                step_map(CMD_MEASURE, rand48());
            end
        end
    endtask

    task automatic test_unused_after_reset();
        step_map(CMD_UNUSED, FIX_MAX);
        step_map(CMD_MEASURE, '0);
        step_map(CMD_TRANSIENT, FIX_MIN);
    endtask

    task automatic test_seed_extremes();
        step_map(CMD_SEED, FIX_MAX);
        step_map(CMD_MEASURE, '0);
        step_map(CMD_SEED, FIX_MIN);
        step_map(CMD_MEASURE, '1);
    endtask

    // constant map so that the episode length is fully controlled
    task automatic test_episode_lifecycle();
        load_map_setup('0, FIX_ONE >> 1, FIX_ONE >> 1, 47'd1 << 30);
        step_map(CMD_SEED, -FIX_ONE);
        repeat (3) step_map(CMD_MEASURE, '0);
        step_map(CMD_UNUSED, '0);
        load_map_setup('0, FIX_ONE >> 1, (FIX_ONE >> 1) + (FIX_ONE << 1), 47'd1 << 30);
        step_map(CMD_MEASURE, '0);
        load_map_setup('0, FIX_ONE >> 1, FIX_ONE >> 1, 47'd1 << 30);
        step_map(CMD_SEED, -FIX_ONE);
        step_map(CMD_MEASURE, '0);
        step_map(CMD_TRANSIENT, '0);
        step_map(CMD_MEASURE, '0);
        step_map(CMD_SEED, FIX_ONE);
    endtask

    task automatic test_saturation();
        load_map_setup(FIX_MAX, FIX_MAX, FIX_MAX, '0);
        step_map(CMD_SEED, '0);
        repeat (2) step_map(CMD_MEASURE, '0);
        load_map_setup(FIX_MIN, FIX_MIN, FIX_MIN, HALF_MAX);
        repeat (2) step_map(CMD_MEASURE, '0);
        load_map_setup(FIX_MIN, FIX_MAX, '0, HALF_MAX);
        step_map(CMD_SEED, '0);
        step_map(CMD_MEASURE, '0);
    endtask

    task automatic test_default_orbit();
        load_map_setup(GAIN_RST, OFFSET_RST, CENTER_RST, WIDTH_RST);
        idle_pct = 0;
        run_orbit_phase(150);
        idle_pct = 17;
        run_orbit_phase(450);
    endtask

    task automatic test_tuned_orbits();
        repeat (5) begin
            load_map_setup(GAIN_RST + jitter48(), OFFSET_RST + jitter48(),
                           CENTER_RST + jitter48(), 47'($urandom_range(16, 512)) << 30);
            run_orbit_phase(100);
        end
    endtask

    task automatic test_extreme_maps();
        load_map_setup(FIX_MAX, FIX_MIN, '0, HALF_MAX);
        run_orbit_phase(150);
        load_map_setup(FIX_MIN, FIX_MAX, FIX_MIN, '0);
        run_orbit_phase(150);
    endtask

    task automatic test_random_maps();
        logic [VAL_W-1:0] w;
        repeat (3) begin
            w = rand48();
            load_map_setup(rand48(), rand48(), rand48(), w[WIDTH_W-1:0]);
            run_orbit_phase(100);
        end
    endtask

    task automatic test_wide_window();
        load_map_setup(GAIN_RST, OFFSET_RST, CENTER_RST, FIX_ONE[WIDTH_W-1:0] >> 1);
        run_orbit_phase(150);
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_orbit_point want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (orbit_q.size() == 0) begin
                report_mismatch("result with no transaction pending",
                                $unsigned(res_ch.next_value), '0);
            end else begin
                want = orbit_q.pop_front();
                if (res_ch.next_value !== want.value)
                    report_mismatch("next_value", $unsigned(res_ch.next_value), want.value);
                if (res_ch.laminar_now !== want.laminar)
                    report_mismatch("laminar_now", res_ch.laminar_now, want.laminar);
                if (res_ch.episode_done !== want.done)
                    report_mismatch("episode_done", res_ch.episode_done, want.done);
                if (res_ch.episode_length !== want.length)
                    report_mismatch("episode_length", res_ch.episode_length, want.length);
                if (res_ch.episode_total !== want.total)
                    report_mismatch("episode_total", res_ch.episode_total, want.total);
                if (res_ch.length_total !== want.sum)
                    report_mismatch("length_total", res_ch.length_total, want.sum);
                if (res_ch.length_peak !== want.peak)
                    report_mismatch("length_peak", res_ch.length_peak, want.peak);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_SEED;
        in_ch.seed_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_GAIN;
        cfg_ch.data      = '0;
        idle_pct         = 17;
        mismatches       = 0;
        gain_r           = GAIN_RST;
        offset_r         = OFFSET_RST;
        center_r         = CENTER_RST;
        width_r          = WIDTH_RST;
        x_now            = '0;
        lam_open         = 1'b0;
        run_len          = '0;
        ep_count         = '0;
        len_sum          = '0;
        len_max          = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unused_after_reset();
        test_seed_extremes();
        test_episode_lifecycle();
        test_saturation();
        test_default_orbit();
        test_tuned_orbits();
        test_extreme_maps();
        test_random_maps();
        test_wide_window();

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (orbit_q.size() != 0)
            report_mismatch("transactions left without a result", orbit_q.size(), '0);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
